// ===== sv/euq_pkg.sv =====
// shared constants, types and rounding helpers for the euler to quaternion pipeline
`timescale 1ns / 1ps
package euq_pkg;
   localparam int CORDIC_STEPS    = 16;
   localparam int ANGLE_FRAC_BITS = 6;
   localparam int TABLE_LEN       = 30;
   localparam int CORDIC_N        = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

   localparam int DEG_W  = 15;
   localparam int ZW     = 34;   // angle accumulator, q30
   localparam int XW     = 34;   // cordic x / y, q30
   localparam int TW     = 22;   // cos / sin, q20
   localparam int PRODW  = 47;   // degree times radian constant
   localparam int PAIRW  = 44;
   localparam int PRW    = 25;   // rounded pair product, q20
   localparam int TRIW   = 48;   // triple product, q40
   localparam int QW     = 16;

   localparam logic signed [PRODW-1:0] DEG2RAD_Q36 = PRODW'(64'd1199381129);
   localparam logic signed [ZW-1:0]    HALF_PI_Q30 = ZW'(64'd1686629713);
   localparam logic signed [ZW-1:0]    PI_Q30      = ZW'(64'd3373259426);
   localparam logic signed [XW-1:0]    GAIN_Q30    = XW'(64'd652032874);
   localparam logic signed [QW-1:0]    Q14_ONE     = QW'(16384);

   localparam logic [31:0] ATAN_Q30 [TABLE_LEN] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
      32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
      32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
      32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
      32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
      32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
   };

   typedef struct packed {
      logic signed [TW-1:0] c;
      logic signed [TW-1:0] s;
   } trig_type;

   // shift right rounding half away from zero, s >= 1
   function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                  input int unsigned s);
      logic [63:0] mag;
      logic [63:0] r;
      mag = v[63] ? 64'(-v) : 64'(v);
      r   = (mag + (64'd1 << (s - 1))) >> s;
      return v[63] ? -$signed(r) : $signed(r);
   endfunction
endpackage

// ===== sv/euq_lane.sv =====
// one angle lane: half angle to radians, range fold, pipelined cordic, cos and sin in q20
`timescale 1ns / 1ps
module euq_lane (
   input  logic                                   clock,
   input  logic                                   en,
   input  logic signed [euq_pkg::DEG_W-1:0]       deg,
   output euq_pkg::trig_type                      trig
);
   localparam int N = euq_pkg::CORDIC_N;

   logic signed [euq_pkg::PRODW-1:0] prod_ff, prod_in;
   logic signed [euq_pkg::ZW-1:0]    z_red_ff, z_red_in, z_raw;
   logic                             flip_red_ff, flip_red_in;
   logic signed [euq_pkg::XW-1:0]    x_st [N+1];
   logic signed [euq_pkg::XW-1:0]    y_st [N+1];
   logic signed [euq_pkg::ZW-1:0]    z_st [N+1];
   logic                             f_st [N+1];
   logic signed [euq_pkg::XW-1:0]    xf, yf;
   euq_pkg::trig_type                trig_ff, trig_in;

   assign prod_in = euq_pkg::PRODW'(deg) * euq_pkg::DEG2RAD_Q36;

   always_comb begin
      z_raw = euq_pkg::ZW'(euq_pkg::rnd_shr(64'(prod_ff),
                                          euq_pkg::ANGLE_FRAC_BITS + 7));
      z_red_in    = z_raw;
      flip_red_in = 1'b0;
      if (z_raw > euq_pkg::HALF_PI_Q30) begin
         z_red_in    = z_raw - euq_pkg::PI_Q30;
         flip_red_in = 1'b1;
      end else if (z_raw < -euq_pkg::HALF_PI_Q30) begin
         z_red_in    = z_raw + euq_pkg::PI_Q30;
         flip_red_in = 1'b1;
      end
   end

   assign x_st[0] = euq_pkg::GAIN_Q30;
   assign y_st[0] = '0;
   assign z_st[0] = z_red_ff;
   assign f_st[0] = flip_red_ff;

   // one micro-rotation per stage
   for (genvar i = 0; i < N; i++) begin : g_rot
      logic signed [euq_pkg::XW-1:0] x_ff, y_ff;
      logic signed [euq_pkg::ZW-1:0] z_ff;
      logic                          f_ff;
      logic signed [euq_pkg::ZW-1:0] atan_c;
      assign atan_c = euq_pkg::ZW'(euq_pkg::ATAN_Q30[i]);
      always_ff @(posedge clock) begin
         if (en) begin
            if (!z_st[i][euq_pkg::ZW-1]) begin
               x_ff <= x_st[i] - (y_st[i] >>> i);
               y_ff <= y_st[i] + (x_st[i] >>> i);
               z_ff <= z_st[i] - atan_c;
            end else begin
               x_ff <= x_st[i] + (y_st[i] >>> i);
               y_ff <= y_st[i] - (x_st[i] >>> i);
               z_ff <= z_st[i] + atan_c;
            end
            f_ff <= f_st[i];
         end
      end
      assign x_st[i+1] = x_ff;
      assign y_st[i+1] = y_ff;
      assign z_st[i+1] = z_ff;
      assign f_st[i+1] = f_ff;
   end

   always_comb begin
      xf = f_st[N] ? -x_st[N] : x_st[N];
      yf = f_st[N] ? -y_st[N] : y_st[N];
      trig_in.c = euq_pkg::TW'(euq_pkg::rnd_shr(64'(xf), 10));
      trig_in.s = euq_pkg::TW'(euq_pkg::rnd_shr(64'(yf), 10));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff     <= prod_in;
         z_red_ff    <= z_red_in;
         flip_red_ff <= flip_red_in;
         trig_ff     <= trig_in;
      end
   end

   assign trig = trig_ff;
endmodule

// ===== sv/euq_merge.sv =====
// merge of the three lanes: pair products, triple products, sums to saturated q14
`timescale 1ns / 1ps
module euq_merge (
   input  logic                              clock,
   input  logic                              en,
   input  euq_pkg::trig_type                 rl,
   input  euq_pkg::trig_type                 pt,
   input  euq_pkg::trig_type                 yw,
   output logic signed [euq_pkg::QW-1:0]     qw,
   output logic signed [euq_pkg::QW-1:0]     qx,
   output logic signed [euq_pkg::QW-1:0]     qy,
   output logic signed [euq_pkg::QW-1:0]     qz
);
   // pair order: cr*cp, sr*sp, sr*cp, cr*sp
   logic signed [euq_pkg::PAIRW-1:0] pa_ff [4];
   logic signed [euq_pkg::PRW-1:0]   pb_ff [4];
   logic signed [euq_pkg::TRIW-1:0]  t_ff  [8];
   logic signed [euq_pkg::QW-1:0]    q_ff  [4];
   euq_pkg::trig_type                yw_a_ff, yw_b_ff;
   logic signed [euq_pkg::TRIW-1:0]  t_in  [8];
   logic signed [euq_pkg::QW-1:0]    q_in  [4];

   function automatic logic signed [euq_pkg::QW-1:0] to_q14(
      input logic signed [euq_pkg::TRIW-1:0] a, input logic signed [euq_pkg::TRIW-1:0] b);
      logic signed [63:0] v;
      v = euq_pkg::rnd_shr(64'(a) + 64'(b), 26);
      if (v > 64'(euq_pkg::Q14_ONE))       return euq_pkg::Q14_ONE;
      else if (v < -64'(euq_pkg::Q14_ONE)) return -euq_pkg::Q14_ONE;
      else                                 return euq_pkg::QW'(v);
   endfunction

   always_comb begin
      // ccc, sss, scc, css, csc, scs, ccs, ssc
      t_in[0] = euq_pkg::TRIW'(pb_ff[0]) * euq_pkg::TRIW'(yw_b_ff.c);
      t_in[1] = euq_pkg::TRIW'(pb_ff[1]) * euq_pkg::TRIW'(yw_b_ff.s);
      t_in[2] = euq_pkg::TRIW'(pb_ff[2]) * euq_pkg::TRIW'(yw_b_ff.c);
      t_in[3] = euq_pkg::TRIW'(pb_ff[3]) * euq_pkg::TRIW'(yw_b_ff.s);
      t_in[4] = euq_pkg::TRIW'(pb_ff[3]) * euq_pkg::TRIW'(yw_b_ff.c);
      t_in[5] = euq_pkg::TRIW'(pb_ff[2]) * euq_pkg::TRIW'(yw_b_ff.s);
      t_in[6] = euq_pkg::TRIW'(pb_ff[0]) * euq_pkg::TRIW'(yw_b_ff.s);
      t_in[7] = euq_pkg::TRIW'(pb_ff[1]) * euq_pkg::TRIW'(yw_b_ff.c);
      q_in[0] = to_q14(t_ff[0], t_ff[1]);
      q_in[1] = to_q14(t_ff[2], -t_ff[3]);
      q_in[2] = to_q14(t_ff[4], t_ff[5]);
      q_in[3] = to_q14(t_ff[6], -t_ff[7]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff[0] <= euq_pkg::PAIRW'(rl.c) * euq_pkg::PAIRW'(pt.c);
         pa_ff[1] <= euq_pkg::PAIRW'(rl.s) * euq_pkg::PAIRW'(pt.s);
         pa_ff[2] <= euq_pkg::PAIRW'(rl.s) * euq_pkg::PAIRW'(pt.c);
         pa_ff[3] <= euq_pkg::PAIRW'(rl.c) * euq_pkg::PAIRW'(pt.s);
         yw_a_ff  <= yw;
         yw_b_ff  <= yw_a_ff;
         for (int k = 0; k < 4; k++) begin
            pb_ff[k] <= euq_pkg::PRW'(euq_pkg::rnd_shr(64'(pa_ff[k]), 20));
            q_ff[k]  <= q_in[k];
         end
         for (int k = 0; k < 8; k++) begin
            t_ff[k] <= t_in[k];
         end
      end
   end

   assign qw = q_ff[0];
   assign qx = q_ff[1];
   assign qy = q_ff[2];
   assign qz = q_ff[3];
endmodule

// ===== sv/euler_to_quaternion.sv =====
// top level: zyx euler angles in degrees to a unit quaternion in q1.14
//
// channel  dir  bits  contents
// req      in   48    roll_deg, pitch_deg, yaw_deg (15 bits signed each)
// rsp      out  64    quat_w (15 unsigned), quat_x, quat_y, quat_z (16 signed)
//
// one beat per cycle sustained while no finished beat is held in the output register
// three lanes each run a pipelined cordic, one stage per micro-rotation
// the merge stage forms the triple products and sums, then the output register
// the whole pipe advances when the output register is empty or being taken
// reset clears the valid pipe and the output valid only
`timescale 1ns / 1ps
module euler_to_quaternion (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // roll_deg[14:0], pitch_deg[29:15], yaw_deg[44:30], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // quat_w[14:0], quat_x[30:15], quat_y[46:31], quat_z[62:47], pad
);
   // lane depth plus four merge stages
   localparam int DEPTH = euq_pkg::CORDIC_N + 7;

   logic                          en;
   logic [DEPTH-1:0]              vld_ff, vld_in;
   euq_pkg::trig_type             trig_r, trig_p, trig_y;
   logic signed [euq_pkg::QW-1:0] mw, mx, my, mz;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [63:0]                   rsp_data_ff, rsp_data_in;
   logic signed [euq_pkg::QW-1:0] ow, ox, oy, oz;

   // stall the whole pipe only while a finished beat is held
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   euq_lane u_lane_roll (
      .clock (clock), .en (en), .deg (req_tdata[14:0]),  .trig (trig_r));
   euq_lane u_lane_pitch (
      .clock (clock), .en (en), .deg (req_tdata[29:15]), .trig (trig_p));
   euq_lane u_lane_yaw (
      .clock (clock), .en (en), .deg (req_tdata[44:30]), .trig (trig_y));

   euq_merge u_merge (
      .clock (clock), .en (en), .rl (trig_r), .pt (trig_p), .yw (trig_y),
      .qw (mw), .qx (mx), .qy (my), .qz (mz));

   always_comb begin
      vld_in = {vld_ff[DEPTH-2:0], req_tvalid};
      // keep the scalar part non-negative
      if (mw < 0) begin
         ow = -mw; ox = -mx; oy = -my; oz = -mz;
      end else begin
         ow = mw;  ox = mx;  oy = my;  oz = mz;
      end
      rsp_data_in  = {1'b0, oz, oy, ox, ow[14:0]};
      rsp_valid_in = vld_ff[DEPTH-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");
   a_ready_rule: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("ready does not follow output register state");
   a_w_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[14:0] <= 15'd16384))
      else $error("scalar part out of range");
   a_x_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[30:15]) <= 16'sd16384 &&
                      $signed(rsp_tdata[30:15]) >= -16'sd16384))
      else $error("x part out of range");
`endif
endmodule

// ===== test/euq_checker.sv =====
// checker: watches both channels, predicts each quaternion and compares it field by field
`timescale 1ns / 1ps
module euq_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,
   output int          fail_count,
   output int          pending_count
);
   typedef struct packed {
      logic [15:0] z;
      logic [15:0] y;
      logic [15:0] x;
      logic [14:0] w;
   } quat_type;

   localparam longint ATAN [30] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
      64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
      64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
      64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
      64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002};

   quat_type quat_queue[$];

   // divide by 2^s, rounding half away from zero
   function automatic longint round_shift(longint v, int s);
      longint mag;
      mag = (v < 0) ? -v : v;
      mag = (mag + (64'sd1 << (s - 1))) >>> s;
      return (v < 0) ? -mag : mag;
   endfunction

   // half angle cosine and sine in q20
   function automatic void half_trig(logic signed [14:0] deg, output longint c,
                                     output longint s);
      longint z, x, y, dx, dy;
      bit flip;
      z = round_shift(longint'(deg) * 64'sd1199381129, euq_pkg::ANGLE_FRAC_BITS + 7);
      flip = 0;
      x = 652032874;
      y = 0;
      if (z > 64'sd1686629713) begin
         z -= 64'sd3373259426; flip = 1;
      end else if (z < -64'sd1686629713) begin
         z += 64'sd3373259426; flip = 1;
      end
      for (int i = 0; i < euq_pkg::CORDIC_STEPS && i < 30; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= ATAN[i];
         end else begin
            x += dx; y -= dy; z += ATAN[i];
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      c = round_shift(x, 10);
      s = round_shift(y, 10);
   endfunction

   function automatic longint tri_prod(longint a, longint b, longint c);
      return round_shift(a * b, 20) * c;
   endfunction

   function automatic longint sat_q14(longint v);
      longint r;
      r = round_shift(v, 26);
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return r;
   endfunction

   function automatic quat_type attitude_to_quat(logic [47:0] d);
      longint cr, sr, cp, sp, cy, sy, w, qx, qy, qz;
      quat_type q;
      half_trig(d[14:0], cr, sr);
      half_trig(d[29:15], cp, sp);
      half_trig(d[44:30], cy, sy);
      w  = sat_q14(tri_prod(cr, cp, cy) + tri_prod(sr, sp, sy));
      qx = sat_q14(tri_prod(sr, cp, cy) - tri_prod(cr, sp, sy));
      qy = sat_q14(tri_prod(cr, sp, cy) + tri_prod(sr, cp, sy));
      qz = sat_q14(tri_prod(cr, cp, sy) - tri_prod(sr, sp, cy));
      if (w < 0) begin
         w = -w; qx = -qx; qy = -qy; qz = -qz;
      end
      q.w = w[14:0]; q.x = qx[15:0]; q.y = qy[15:0]; q.z = qz[15:0];
      return q;
   endfunction

   always @(posedge clock) begin
      quat_type got, want;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_tvalid && req_tready) quat_queue.push_back(attitude_to_quat(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[62:0];
            if (quat_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected beat %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = quat_queue.pop_front();
               if (got != want || rsp_tdata[63]) begin
                  if (fail_count < 10)
                     $display("mismatch w %0d/%0d x %0d/%0d y %0d/%0d z %0d/%0d",
                              want.w, got.w, $signed(want.x), $signed(got.x),
                              $signed(want.y), $signed(got.y),
                              $signed(want.z), $signed(got.z));
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending_count <= quat_queue.size();
   end
endmodule

// ===== test/tb_top.sv =====
// testbench top: drives random attitudes into euler_to_quaternion and reports the verdict
`timescale 1ns / 1ps
module tb_top;
   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // roll, pitch, yaw from bit 0 up
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [63:0] rsp_tdata;        // w, x, y, z from bit 0 up
   int          fail_count, pending_count;
   int          idle_pct = 0, stall_pct = 0, quiet_cycles = 0;

   always #4 clock = ~clock;

   euler_to_quaternion u_dut (.*);
   euq_checker u_chk (.*);

   // receiver stalls at random
   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= stall_pct);

   // watchdog on cycles with no beat on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // sends one beat, idling first at the current rate
   task automatic send_attitude(logic [14:0] r, logic [14:0] p, logic [14:0] y);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {3'b0, y, p, r};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [14:0] rand_angle();
      case ($urandom_range(3))
         0: return 15'($urandom_range(23040) - 11520);
         1: return 15'($urandom);                            // whole 15-bit range
         2: return 15'($signed(($urandom_range(8) - 4) * 2880 + $urandom_range(4) - 2));
         default: return 15'($urandom_range(2880) - 1440);
      endcase
   endfunction

   initial begin
      logic [14:0] edges [10];
      edges = '{15'h0000, 15'h4000, 15'h3FFF, 15'h0001, 15'h7FFF,
                15'd11520, -15'sd11520, 15'd5760, -15'sd5760, 15'd2880};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: field extremes, right angles, half turns, negative scalar part
      foreach (edges[i]) send_attitude(edges[i], edges[(i + 3) % 10], edges[(i + 7) % 10]);
      send_attitude(15'd11520, 15'd0, 15'd0);
      send_attitude(15'd0, 15'd11520, 15'd11520);
      send_attitude(15'd11520, 15'd11520, 15'd11520);
      send_attitude(-15'sd11520, 15'd5760, -15'sd5760);
      send_attitude(15'h7FFF, 15'h7FFF, 15'h7FFF);
      send_attitude(15'h4000, 15'h4000, 15'h4000);
      // hold off until the pipe has drained
      req_tvalid <= 0;
      while (pending_count != 0) @(negedge clock);
      for (int phase = 0; phase < 4; phase++) begin
         idle_pct  = (phase == 1 || phase == 3) ? ((phase == 3) ? 13 : 57) : 0;
         stall_pct = (phase == 2) ? 57 : ((phase == 3) ? 13 : 0);
         repeat (345) send_attitude(rand_angle(), rand_angle(), rand_angle());
      end
      req_tvalid <= 0;
      stall_pct = 0;
      while (pending_count != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end
endmodule
